[rtl/dlc_pkg.sv]
// Shared types and constants for the dimmer level controller.
package dlc_pkg;

  // Command codes on the func field
  localparam logic [1:0] FUNC_LEVEL = 2'd0;
  localparam logic [1:0] FUNC_ONOFF = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_PERCENT_MODE    = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_HIGH     = 2'd1;
  localparam logic [1:0] CFG_MAX_LEVEL       = 2'd2;
  localparam logic [1:0] CFG_STARTUP_TIMEOUT = 2'd3;

  // Configuration reset values
  localparam logic        RST_PERCENT_MODE    = 1'b0;
  localparam logic        RST_ACTIVE_HIGH     = 1'b1;
  localparam logic [15:0] RST_MAX_LEVEL       = 16'd255;
  localparam logic [15:0] RST_STARTUP_TIMEOUT = 16'd5000;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Percent scaling: (p*max + 50) / 100, divide done as multiply by
  // ceil(2^30/100) and a 30-bit shift, exact for dividends below 2^23.
  localparam logic [15:0] PCT_FULL   = 16'd100;
  localparam logic [22:0] PCT_HALF   = 23'd50;
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_100  = 24'd10737419;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic               duty_valid;
    logic [15:0]        duty;
    logic               report_kind;
    logic signed [15:0] report_value;
    logic               last;
  } out_t;

endpackage

[rtl/dimmer_level_controller.sv]
// Dimmer level controller: command decode, duty scaling and result sequencing.
// An item's first result goes through the input, product and result registers.
// One item per cycle in unless stalled; a two-result item holds the output for both.
// Stages: input, product (percent multiply) and result (reciprocal divide) registers.
// Reset (rst_n low, synchronous): pipeline empty, configuration to defaults, level to
//   "use max level", tick count and flag cleared.
module dimmer_level_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dlc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dlc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [15:0]   cfg_wdata
);
  import dlc_pkg::*;

  // configuration
  logic        percent_mode_r;
  logic        active_high_r;
  logic [15:0] max_level_r;
  logic [15:0] startup_timeout_r;

  // block state
  logic [15:0] saved_level_r;
  logic        level_saved_r;
  logic        command_seen_r;
  logic [15:0] elapsed_ticks_r;

  // stage 0: input register
  logic        s0_v_r;
  in_t         s0_r;

  // stage 1: product register
  logic        s1_v_r;
  logic [22:0] s1_x_r;
  logic        s1_kind_r;
  logic [15:0] s1_val_r;
  logic        s1_stat_r;
  logic        s1_single_r;

  // stage 2: result register
  logic        s2_v_r;
  logic        s2_idx_r;
  logic [15:0] s2_duty_r;
  logic        s2_kind_r;
  logic [15:0] s2_val_r;
  logic        s2_stat_r;
  logic        s2_single_r;

  logic        out_xfer;
  logic        head_last;
  logic        s2_load;
  logic        s0_adv;

  assign out_xfer  = s2_v_r && !out_stall;
  assign head_last = s2_idx_r || s2_single_r;
  assign s2_load   = s1_v_r && (!s2_v_r || (out_xfer && head_last));
  assign s0_adv    = s0_v_r && (!s1_v_r || s2_load);
  assign in_stall  = s0_v_r && !s0_adv;

  // ---------------- stage 0 decode ----------------
  logic [15:0] u;
  logic        positive;
  logic [15:0] lvl;
  logic [15:0] elapsed_inc;
  logic        fire;
  logic        has_res;
  logic [15:0] d_in;
  logic [6:0]  pct;
  logic [22:0] x_nxt;
  logic        kind_nxt;
  logic [15:0] val_nxt;
  logic        stat_nxt;
  logic        single_nxt;

  always_comb begin
    u           = s0_r.value;
    positive    = (u != 16'd0) && !u[15];
    lvl         = level_saved_r ? saved_level_r : max_level_r;
    elapsed_inc = (elapsed_ticks_r != TICK_MAX) ? elapsed_ticks_r + 16'd1 : elapsed_ticks_r;
    fire        = !command_seen_r && (elapsed_inc > startup_timeout_r);
    has_res     = 1'b0;
    d_in        = 16'd0;
    kind_nxt    = 1'b0;
    val_nxt     = 16'd0;
    stat_nxt    = 1'b0;
    single_nxt  = 1'b0;
    case (s0_r.func)
      FUNC_LEVEL: begin
        has_res  = 1'b1;
        d_in     = u;
        val_nxt  = u;
        stat_nxt = positive;
      end
      FUNC_ONOFF: begin
        has_res = 1'b1;
        if (u == 16'd0) begin
          kind_nxt   = 1'b1;
          single_nxt = 1'b1;
        end else begin
          d_in     = lvl;
          val_nxt  = lvl;
          stat_nxt = 1'b1;
        end
      end
      FUNC_TICK: begin
        has_res = fire;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
    pct = (d_in > PCT_FULL) ? PCT_FULL[6:0] : d_in[6:0];
    if (percent_mode_r) begin
      x_nxt = {16'd0, pct} * {7'd0, max_level_r} + PCT_HALF;
    end else begin
      x_nxt = {7'd0, d_in};
    end
  end

  // ---------------- stage 1 scaling ----------------
  logic [46:0] q_prod;
  logic [15:0] duty_raw;
  logic [15:0] duty_nxt;

  always_comb begin
    q_prod   = {24'd0, s1_x_r} * {23'd0, RECIP_100};
    duty_raw = percent_mode_r ? q_prod[RECIP_SHIFT +: 16] : s1_x_r[15:0];
    duty_nxt = active_high_r ? duty_raw : max_level_r - duty_raw;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      percent_mode_r    <= RST_PERCENT_MODE;
      active_high_r     <= RST_ACTIVE_HIGH;
      max_level_r       <= RST_MAX_LEVEL;
      startup_timeout_r <= RST_STARTUP_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PERCENT_MODE:    percent_mode_r    <= cfg_wdata[0];
        CFG_ACTIVE_HIGH:     active_high_r     <= cfg_wdata[0];
        CFG_MAX_LEVEL:       max_level_r       <= cfg_wdata;
        CFG_STARTUP_TIMEOUT: startup_timeout_r <= cfg_wdata;
        default:             max_level_r       <= max_level_r;
      endcase
    end
  end

  // state updates happen as an item leaves stage 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_saved_r   <= 1'b0;
      command_seen_r  <= 1'b0;
      elapsed_ticks_r <= 16'd0;
    end else if (s0_adv) begin
      if (s0_r.func == FUNC_LEVEL) begin
        command_seen_r <= 1'b1;
        if (u != 16'd0) begin
          level_saved_r <= 1'b1;
        end
      end
      if (s0_r.func == FUNC_TICK) begin
        elapsed_ticks_r <= elapsed_inc;
        if (fire) begin
          command_seen_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && s0_r.func == FUNC_LEVEL && u != 16'd0) begin
      saved_level_r <= u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (!in_stall) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s0_adv) begin
      s1_v_r <= has_res;
    end else if (s2_load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_x_r      <= x_nxt;
      s1_kind_r   <= kind_nxt;
      s1_val_r    <= val_nxt;
      s1_stat_r   <= stat_nxt;
      s1_single_r <= single_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r   <= 1'b0;
      s2_idx_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r   <= 1'b1;
      s2_idx_r <= 1'b0;
    end else if (out_xfer) begin
      // drop after the final result, else advance to the status report
      if (head_last) begin
        s2_v_r <= 1'b0;
      end else begin
        s2_idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_duty_r   <= duty_nxt;
      s2_kind_r   <= s1_kind_r;
      s2_val_r    <= s1_val_r;
      s2_stat_r   <= s1_stat_r;
      s2_single_r <= s1_single_r;
    end
  end

  // ---------------- result channel ----------------
  assign out_valid = s2_v_r;

  always_comb begin
    if (s2_idx_r) begin
      out_data.duty_valid   = 1'b0;
      out_data.duty         = 16'd0;
      out_data.report_kind  = 1'b1;
      out_data.report_value = {15'd0, s2_stat_r};
      out_data.last         = 1'b1;
    end else begin
      out_data.duty_valid   = 1'b1;
      out_data.duty         = s2_duty_r;
      out_data.report_kind  = s2_kind_r;
      out_data.report_value = s2_val_r;
      out_data.last         = s2_single_r;
    end
  end

endmodule

[rtl/dlc_checker.sv]
// Port-level checks for the dimmer level controller, bound to the top level.
module dlc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input dlc_pkg::out_t out_data
);
  import dlc_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a result that carries no duty is always the closing status report
  a_nodut_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.duty_valid |-> out_data.last && out_data.report_kind)
    else $error("duty-less result is not a final status report");

  // after a non-final transfer the status report follows at once
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.report_kind && !out_data.duty_valid)
    else $error("second result of a pair missing");

  // reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dimmer_level_controller dlc_checker u_dlc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/tb.sv]
// Self-checking testbench for the dimmer level controller: directed and random commands.
module tb;
  import dlc_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 12;
  localparam int TIMEOUT_CYCLES = 1500000;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_COMMANDS = 97;
  localparam int MAX_PRINTED    = 40;

  localparam logic REPORT_LEVEL  = 1'b0;
  localparam logic REPORT_STATUS = 1'b1;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = CFG_PERCENT_MODE;
  logic [15:0] cfg_wdata = '0;

  // Predictor copy of configuration and dimmer state
  logic        pct_mode_q     = RST_PERCENT_MODE;
  logic        act_high_q     = RST_ACTIVE_HIGH;
  logic [15:0] max_level_q    = RST_MAX_LEVEL;
  logic [15:0] timeout_q      = RST_STARTUP_TIMEOUT;
  logic [15:0] saved_level_q  = '0;
  logic        level_saved_q  = 1'b0;
  logic        command_seen_q = 1'b0;
  logic [15:0] tick_count_q   = '0;

  in_t  pending_commands[$];
  out_t expected_dimmer_out[$];

  int   mismatches   = 0;
  int   results_seen = 0;
  int   send_gap     = 0;
  int   stall_left   = 0;
  bit   idle_in      = 1'b0;
  bit   idle_out     = 1'b0;

  dimmer_level_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] scaled_duty(logic [15:0] u);
    logic [31:0] d;
    d = {16'h0, u};
    if (pct_mode_q) begin
      if (d > 32'd100) d = 32'd100;
      d = (d * {16'h0, max_level_q} + 32'd50) / 32'd100;
    end
    if (!act_high_q) d = {16'h0, max_level_q} - d;
    return d[15:0];
  endfunction

  function automatic void push_result(logic dv, logic [15:0] duty, logic kind,
                                      logic [15:0] rv, logic last);
    out_t r;
    r.duty_valid   = dv;
    r.duty         = duty;
    r.report_kind  = kind;
    r.report_value = rv;
    r.last         = last;
    expected_dimmer_out.push_back(r);
  endfunction

  function automatic void predict_dimmer(in_t cmd);
    logic [15:0] u;
    logic [15:0] lvl;
    u = cmd.value;
    case (cmd.func)
      FUNC_LEVEL: begin
        push_result(1'b1, scaled_duty(u), REPORT_LEVEL, u, 1'b0);
        push_result(1'b0, 16'h0, REPORT_STATUS, {15'h0, (u != 16'h0) && !u[15]}, 1'b1);
        if (u != 16'h0) begin
          saved_level_q = u;
          level_saved_q = 1'b1;
        end
        command_seen_q = 1'b1;
      end
      FUNC_ONOFF: begin
        if (u == 16'h0) begin
          push_result(1'b1, scaled_duty(16'h0), REPORT_STATUS, 16'h0, 1'b1);
        end else begin
          lvl = level_saved_q ? saved_level_q : max_level_q;
          push_result(1'b1, scaled_duty(lvl), REPORT_LEVEL, lvl, 1'b0);
          push_result(1'b0, 16'h0, REPORT_STATUS, 16'h1, 1'b1);
        end
      end
      FUNC_TICK: begin
        if (tick_count_q != TICK_MAX) tick_count_q = tick_count_q + 16'h1;
        // force the output off once if no level command came in time
        if (!command_seen_q && tick_count_q > timeout_q) begin
          push_result(1'b1, scaled_duty(16'h0), REPORT_LEVEL, 16'h0, 1'b0);
          push_result(1'b0, 16'h0, REPORT_STATUS, 16'h0, 1'b1);
          command_seen_q = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (expected_dimmer_out.size() == 0) begin
      flag_mismatch($sformatf("result %0d not expected, data %h", results_seen, got));
      results_seen++;
      return;
    end
    want = expected_dimmer_out.pop_front();
    if (got.duty_valid !== want.duty_valid)
      flag_mismatch($sformatf("result %0d duty_valid %b, want %b", results_seen,
                              got.duty_valid, want.duty_valid));
    if (got.duty !== want.duty)
      flag_mismatch($sformatf("result %0d duty %h, want %h", results_seen,
                              got.duty, want.duty));
    if (got.report_kind !== want.report_kind)
      flag_mismatch($sformatf("result %0d report_kind %b, want %b", results_seen,
                              got.report_kind, want.report_kind));
    if (got.report_value !== want.report_value)
      flag_mismatch($sformatf("result %0d report_value %h, want %h", results_seen,
                              got.report_value, want.report_value));
    if (got.last !== want.last)
      flag_mismatch($sformatf("result %0d last %b, want %b", results_seen,
                              got.last, want.last));
    results_seen++;
  endtask

  // Input driver: predict on each transfer, then load the next command or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_dimmer(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_commands.size() > 0) begin
          in_data  <= pending_commands.pop_front();
          in_valid <= 1'b1;
          send_gap = idle_in ? gap_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_out ? gap_len() : 0;
      end
    end
  end

  task automatic set_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_PERCENT_MODE:    pct_mode_q  = data[0];
      CFG_ACTIVE_HIGH:     act_high_q  = data[0];
      CFG_MAX_LEVEL:       max_level_q = data;
      CFG_STARTUP_TIMEOUT: timeout_q   = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_cmd(logic [1:0] func, logic [15:0] value);
    in_t cmd;
    cmd.func  = func;
    cmd.value = value;
    pending_commands.push_back(cmd);
  endtask

  // Hold the sender until every expected result is back, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (pending_commands.size() != 0 || in_valid || expected_dimmer_out.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom_range(0, 120));
      4: begin
        case ($urandom_range(0, 6))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'd100;
          3: return 16'd101;
          4: return 16'h7FFF;
          5: return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_max();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return RST_MAX_LEVEL;
      3: return 16'($urandom_range(1, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t random_command();
    in_t cmd;
    int  r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      cmd.func  = FUNC_LEVEL;
      cmd.value = random_value();
    end else if (r < 80) begin
      cmd.func  = FUNC_ONOFF;
      cmd.value = ($urandom_range(0, 9) < 4) ? 16'h0 : random_value();
    end else if (r < 95) begin
      cmd.func  = FUNC_TICK;
      cmd.value = 16'($urandom);
    end else begin
      cmd.func  = FUNC_NONE;
      cmd.value = 16'($urandom);
    end
    return cmd;
  endfunction

  initial begin
    in_t cmd;
    int  counted;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    idle_in  = 1'b1;
    idle_out = 1'b1;

    // No level command yet: on restores max level, ticks stay quiet
    set_reg(CFG_STARTUP_TIMEOUT, 16'hFFFF);
    queue_cmd(FUNC_ONOFF, 16'h0001);
    queue_cmd(FUNC_ONOFF, 16'h0000);
    queue_cmd(FUNC_ONOFF, 16'hFFFF);
    queue_cmd(FUNC_NONE, 16'h1234);
    queue_cmd(FUNC_NONE, 16'hFFFF);
    repeat (3) queue_cmd(FUNC_TICK, 16'h0000);
    queue_cmd(FUNC_ONOFF, 16'h8000);
    drain();

    // Timeout fires on the next tick, then level extremes and restore
    set_reg(CFG_STARTUP_TIMEOUT, 16'h0000);
    queue_cmd(FUNC_TICK, 16'hFFFF);
    queue_cmd(FUNC_TICK, 16'h0000);
    queue_cmd(FUNC_LEVEL, 16'h0000);
    queue_cmd(FUNC_LEVEL, 16'h0001);
    queue_cmd(FUNC_LEVEL, 16'd100);
    queue_cmd(FUNC_LEVEL, 16'h7FFF);
    queue_cmd(FUNC_LEVEL, 16'h8000);
    queue_cmd(FUNC_LEVEL, 16'hFFFF);
    queue_cmd(FUNC_ONOFF, 16'h0001);
    queue_cmd(FUNC_LEVEL, 16'h0000);
    queue_cmd(FUNC_ONOFF, 16'h0005);
    drain();

    // Percent scaling with clamp, inverted output at full scale
    set_reg(CFG_PERCENT_MODE, 16'h0001);
    set_reg(CFG_ACTIVE_HIGH, 16'h0000);
    set_reg(CFG_MAX_LEVEL, 16'hFFFF);
    queue_cmd(FUNC_LEVEL, 16'd50);
    queue_cmd(FUNC_LEVEL, 16'd101);
    queue_cmd(FUNC_LEVEL, 16'hFFFF);
    queue_cmd(FUNC_ONOFF, 16'h0000);
    drain();

    set_reg(CFG_MAX_LEVEL, 16'h0000);
    set_reg(CFG_STARTUP_TIMEOUT, 16'd65534);
    queue_cmd(FUNC_LEVEL, 16'd100);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_in  = (ph != 0) && ($urandom_range(0, 3) != 0);
      idle_out = (ph != 0) && ($urandom_range(0, 3) != 0);
      if (ph == 0 || $urandom_range(0, 1)) set_reg(CFG_PERCENT_MODE, 16'($urandom_range(0, 1)));
      if (ph == 0 || $urandom_range(0, 1)) set_reg(CFG_ACTIVE_HIGH, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) set_reg(CFG_MAX_LEVEL, random_max());
      if ($urandom_range(0, 3) == 0) set_reg(CFG_STARTUP_TIMEOUT, 16'($urandom_range(0, 65534)));
      counted = 0;
      while (counted < PHASE_COMMANDS) begin
        cmd = random_command();
        pending_commands.push_back(cmd);
        if (cmd.func != FUNC_NONE) counted++;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("dimmer_level_controller verification clean");
    end else begin
      $display("dimmer_level_controller verification failed");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("dimmer_level_controller verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/dlc_pkg.sv
rtl/dimmer_level_controller.sv
rtl/dlc_checker.sv
tb/sv/tb.sv
